FILE: rtl/pqa_pkg.sv
// ----------------------------------------------------------------------------
// pqa_pkg: shared types and constants for the aging priority queue
// Entry layout, command and result codes, sequencer states.
// ----------------------------------------------------------------------------
package pqa_pkg;

    localparam logic [1:0]  CMD_REGISTER = 2'd0;
    localparam logic [1:0]  CMD_TICK     = 2'd1;
    localparam logic [1:0]  CMD_FIND     = 2'd2;
    localparam logic [1:0]  CMD_MARK     = 2'd3;

    localparam logic [1:0]  RES_DONE     = 2'd0;
    localparam logic [1:0]  RES_NOTFOUND = 2'd1;
    localparam logic [1:0]  RES_FULL     = 2'd2;

    localparam logic [15:0] PRIO_MAX     = 16'hFFFF;
    localparam logic [2:0]  THR_RESET    = 3'd3;
    localparam logic [15:0] EPRI_RESET   = 16'd9999;

    localparam logic        CFG_THR      = 1'b0;
    localparam logic        CFG_EPRI     = 1'b1;

    localparam int          ENTRY_W      = 37;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] prio;
        logic [2:0]  wait_cnt;
        logic        pending;
        logic        emerg;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AG_RD,
        ST_AG_EV,
        ST_BACK,
        ST_FWD,
        ST_PLACE,
        ST_FIND,
        ST_HEAD_RD,
        ST_HEAD_EV,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/pqa_ram.sv
// ----------------------------------------------------------------------------
// pqa_ram: generic single-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pqa_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/priority_queue_with_aging.sv
// ----------------------------------------------------------------------------
// priority_queue_with_aging: sorted entry table with anti-starvation aging
// Sequencer over a one-read, one-write entry RAM and one priority comparator.
// ----------------------------------------------------------------------------
// One item is taken at a time; o_ready is high only while the block is idle.
// Every step goes through the entry RAM, one read and one write per cycle, so
// the RAM port sets the latency. A registration moves back the entries behind
// its insertion point one by one; a find or mark scans from the head up to the
// position reached; an aging tick visits every entry and re-places each entry
// that reaches the wait threshold, moving the entries it passes. The result
// stays on the output until taken. No clearing pass is needed: only entries
// below the fill count are ever read.
// ----------------------------------------------------------------------------
module priority_queue_with_aging
    import pqa_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_item_id,
    input  logic [15:0] i_base_priority,
    input  logic        i_is_emergency,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_code,
    output logic [15:0] o_found_priority,
    output logic [3:0]  o_found_position,
    output logic        o_found_pending,
    output logic [2:0]  o_found_wait,
    output logic [4:0]  o_moved_count,
    output logic [4:0]  o_entry_count,
    output logic [15:0] o_head_id,
    output logic [15:0] o_head_priority
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    t_state        r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [15:0]   r_id, n_id;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_total, n_total;
    t_entry        r_ent, n_ent;
    logic          r_from_reg, n_from_reg;
    logic [1:0]    r_code, n_code;
    logic [15:0]   r_fprio, n_fprio;
    logic [3:0]    r_fpos, n_fpos;
    logic          r_fpend, n_fpend;
    logic [2:0]    r_fwait, n_fwait;
    logic [4:0]    r_moved, n_moved;
    logic [15:0]   r_head_id, n_head_id;
    logic [15:0]   r_head_prio, n_head_prio;
    logic [2:0]    r_thr;
    logic [15:0]   r_epri;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rd;
    logic [ENTRY_W-1:0] rdata_raw;
    logic [3:0]    wait_inc;
    logic          prio_less;

    pqa_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rd        = t_entry'(rdata_raw);
    assign wait_inc  = {1'b0, rd.wait_cnt} + 4'd1;
    // shared comparator: stored entry below the one being placed
    assign prio_less = rd.prio < r_ent.prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_thr   <= THR_RESET;
            r_epri  <= EPRI_RESET;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THR:  r_thr  <= i_cfg_data[2:0];
                    CFG_EPRI: r_epri <= i_cfg_data;
                    default:  r_thr  <= r_thr;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_id        <= n_id;
        r_k         <= n_k;
        r_i         <= n_i;
        r_ent       <= n_ent;
        r_from_reg  <= n_from_reg;
        r_code      <= n_code;
        r_fprio     <= n_fprio;
        r_fpos      <= n_fpos;
        r_fpend     <= n_fpend;
        r_fwait     <= n_fwait;
        r_moved     <= n_moved;
        r_head_id   <= n_head_id;
        r_head_prio <= n_head_prio;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_k         = r_k;
        n_i         = r_i;
        n_total     = r_total;
        n_ent       = r_ent;
        n_from_reg  = r_from_reg;
        n_code      = r_code;
        n_fprio     = r_fprio;
        n_fpos      = r_fpos;
        n_fpend     = r_fpend;
        n_fwait     = r_fwait;
        n_moved     = r_moved;
        n_head_id   = r_head_id;
        n_head_prio = r_head_prio;
        we          = 1'b0;
        waddr       = '0;
        wdata       = rd;
        raddr       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_id    = i_item_id;
                    n_code  = RES_DONE;
                    n_fprio = '0;
                    n_fpos  = '0;
                    n_fpend = 1'b0;
                    n_fwait = '0;
                    n_moved = '0;
                    unique case (i_cmd)
                        CMD_REGISTER: begin
                            n_ent.id       = i_item_id;
                            n_ent.prio     = i_is_emergency ? r_epri : i_base_priority;
                            n_ent.wait_cnt = '0;
                            n_ent.pending  = 1'b1;
                            n_ent.emerg    = i_is_emergency;
                            n_from_reg     = 1'b1;
                            if (r_total >= FULL_CNT) begin
                                n_code  = RES_FULL;
                                n_state = ST_HEAD_RD;
                            end else if (r_total == '0) begin
                                n_k     = '0;
                                n_state = ST_PLACE;
                            end else begin
                                n_k     = r_total - ONE;
                                raddr   = AW'(r_total - ONE);
                                n_state = ST_BACK;
                            end
                        end
                        CMD_TICK: begin
                            n_i     = '0;
                            n_state = ST_AG_RD;
                        end
                        default: begin
                            if (r_total == '0) begin
                                n_code  = RES_NOTFOUND;
                                n_state = ST_HEAD_RD;
                            end else begin
                                n_k     = '0;
                                raddr   = '0;
                                n_state = ST_FIND;
                            end
                        end
                    endcase
                end
            end

            ST_BACK: begin
                // shift lower-priority entries down until the slot is found
                if (prio_less) begin
                    we    = 1'b1;
                    waddr = AW'(r_k + ONE);
                    wdata = rd;
                    if (r_k == '0) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_k   = r_k - ONE;
                        raddr = AW'(r_k - ONE);
                    end
                end else begin
                    n_k     = r_k + ONE;
                    n_state = ST_PLACE;
                end
            end

            ST_FWD: begin
                // saturated entry: move equals up, place behind them
                if (rd.prio == PRIO_MAX) begin
                    we    = 1'b1;
                    waddr = AW'(r_k - ONE);
                    wdata = rd;
                    if (CW'(r_k + ONE) < r_total) begin
                        n_k   = r_k + ONE;
                        raddr = AW'(r_k + ONE);
                    end else begin
                        n_state = ST_PLACE;
                    end
                end else begin
                    n_k     = r_k - ONE;
                    n_state = ST_PLACE;
                end
            end

            ST_PLACE: begin
                we    = 1'b1;
                waddr = AW'(r_k);
                wdata = r_ent;
                if (r_from_reg) begin
                    n_total = r_total + ONE;
                    n_fprio = r_ent.prio;
                    n_fpos  = (32'(r_k) > 32'd15) ? 4'd15 : 4'(r_k);
                    n_fpend = 1'b1;
                    n_state = ST_HEAD_RD;
                end else begin
                    n_moved = (r_moved == 5'd31) ? r_moved : r_moved + 5'd1;
                    // revisit the slot if the entry went further down
                    if (r_k <= r_i) begin
                        n_i = r_i + ONE;
                    end
                    n_state = ST_AG_RD;
                end
            end

            ST_AG_RD: begin
                if (r_i >= r_total) begin
                    n_state = ST_HEAD_RD;
                end else begin
                    raddr   = AW'(r_i);
                    n_state = ST_AG_EV;
                end
            end

            ST_AG_EV: begin
                n_state = ST_AG_RD;
                if (rd.pending && !rd.emerg) begin
                    if (wait_inc >= {1'b0, r_thr}) begin
                        n_ent          = rd;
                        n_ent.wait_cnt = '0;
                        n_from_reg     = 1'b0;
                        if (rd.prio != PRIO_MAX) begin
                            n_ent.prio = rd.prio + 16'd1;
                            if (r_i == '0) begin
                                n_k     = '0;
                                n_state = ST_PLACE;
                            end else begin
                                n_k     = r_i - ONE;
                                raddr   = AW'(r_i - ONE);
                                n_state = ST_BACK;
                            end
                        end else if (CW'(r_i + ONE) < r_total) begin
                            n_k     = r_i + ONE;
                            raddr   = AW'(r_i + ONE);
                            n_state = ST_FWD;
                        end else begin
                            n_k     = r_i;
                            n_state = ST_PLACE;
                        end
                    end else begin
                        we             = 1'b1;
                        waddr          = AW'(r_i);
                        wdata          = rd;
                        wdata.wait_cnt = wait_inc[2:0];
                        n_i            = r_i + ONE;
                    end
                end else begin
                    n_i = r_i + ONE;
                end
            end

            ST_FIND: begin
                if (rd.id == r_id) begin
                    if (r_cmd == CMD_MARK) begin
                        we            = 1'b1;
                        waddr         = AW'(r_k);
                        wdata         = rd;
                        wdata.pending = 1'b0;
                    end
                    n_fprio = rd.prio;
                    n_fpos  = (32'(r_k) > 32'd15) ? 4'd15 : 4'(r_k);
                    n_fpend = (r_cmd == CMD_MARK) ? 1'b0 : rd.pending;
                    n_fwait = rd.wait_cnt;
                    n_state = ST_HEAD_RD;
                end else if (CW'(r_k + ONE) < r_total) begin
                    n_k   = r_k + ONE;
                    raddr = AW'(r_k + ONE);
                end else begin
                    n_code  = RES_NOTFOUND;
                    n_state = ST_HEAD_RD;
                end
            end

            ST_HEAD_RD: begin
                if (r_total == '0) begin
                    n_head_id   = '0;
                    n_head_prio = '0;
                    n_state     = ST_OUT;
                end else begin
                    raddr   = '0;
                    n_state = ST_HEAD_EV;
                end
            end

            ST_HEAD_EV: begin
                n_head_id   = rd.id;
                n_head_prio = rd.prio;
                n_state     = ST_OUT;
            end

            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = (r_state == ST_OUT);
    assign o_result_code    = r_code;
    assign o_found_priority = r_fprio;
    assign o_found_position = r_fpos;
    assign o_found_pending  = r_fpend;
    assign o_found_wait     = r_fwait;
    assign o_moved_count    = r_moved;
    assign o_entry_count    = (32'(r_total) > 32'd31) ? 5'd31 : 5'(r_total);
    assign o_head_id        = r_head_id;
    assign o_head_priority  = r_head_prio;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL_CNT)
        else $error("entry count beyond table depth");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("item accepted while a result waits");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready)
        else $error("block not idle after result taken");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_code == RES_FULL) |->
            (r_total == FULL_CNT && o_found_priority == 16'd0))
        else $error("registration dropped without a full table");

endmodule
